// ===== hw/rtl/mpms_pkg.sv =====
// ----------------------------------------------------------------------------
// mpms_pkg
// Shared types and constants of the spectral peak match scorer.
// ----------------------------------------------------------------------------
package mpms_pkg;

   localparam int MZ_W         = 26;
   localparam int INTEN_W      = 32;
   localparam int PPM_W        = 10;
   localparam int TOTAL_W      = 40;
   localparam int FRACTION_W   = 17;
   localparam int ENTRIES_W    = 9;
   localparam int DELTA_W      = 17;

   localparam int DEFAULT_MAX_LIB_PEAKS   = 256;
   localparam int DEFAULT_SCORE_FRAC_BITS = 16;

   localparam logic [PPM_W-1:0]   PPM_RESET  = 10'd10;
   localparam logic [MZ_W-1:0]    MZ_MAX     = 26'h3FF_FFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 40'hFF_FFFF_FFFF;

   // Division by one million: floor(2^40 / 10^6) gives a quotient that is
   // at most one short, fixed by a single compare against the remainder.
   localparam logic [19:0] PPM_SCALE   = 20'd1000000;
   localparam logic [20:0] PPM_RECIP   = 21'd1099511;
   localparam int          RECIP_SHIFT = 40;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_CLEAR  = 2'd3
   } mpms_action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_MUL,
      ST_LD_RECIP,
      ST_LD_BACK,
      ST_LD_WRITE,
      ST_PROBE,
      ST_COMPARE,
      ST_DIV_CNT,
      ST_WAIT_CNT,
      ST_DIV_INT,
      ST_WAIT_INT,
      ST_REPORT
   } mpms_state_type;

endpackage

// ===== hw/rtl/mpms_div.sv =====
// ----------------------------------------------------------------------------
// mpms_div
// Restoring divider for a fraction no larger than one, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module mpms_div #(
   parameter int FRAC_BITS = mpms_pkg::DEFAULT_SCORE_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mpms_pkg::TOTAL_W-1:0] numer,
   input  logic [mpms_pkg::TOTAL_W-1:0] denom,
   output logic                       done,
   output logic [FRAC_BITS:0]         quot
);
   import mpms_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 2);

   logic [TOTAL_W:0]   rem_ff;
   logic [TOTAL_W-1:0] den_ff;
   logic [FRAC_BITS:0] q_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               done_ff;
   logic               ge;
   logic [TOTAL_W:0]   diff;

   assign ge   = rem_ff >= {1'b0, den_ff};
   assign diff = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(FRAC_BITS + 1);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, numer};
         den_ff <= denom;
         q_ff   <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= {diff[TOTAL_W-1:0], 1'b0};
         q_ff   <= {q_ff[FRAC_BITS-1:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== hw/rtl/ms2_peak_match_scorer.sv =====
// ----------------------------------------------------------------------------
// ms2_peak_match_scorer
// Matches sample fragment peaks against one library spectrum within a ppm
// tolerance and scores the match.
// ----------------------------------------------------------------------------
// A library load runs the multiply chain (LD_MUL, LD_RECIP, LD_BACK) that scales
// m/z by the tolerance and divides by one million, then writes the window in
// LD_WRITE. A sample peak takes a probe and a compare state per binary search
// step; each compare follows a registered read of the window memory in the probe
// state. Finish uses the shared bit-serial divider for each fraction whose divisor
// is nonzero, and ends with one result item on the rsp_ ports for one cycle under
// rsp_valid; the receiver cannot stall it, so it must take the item in that cycle.
// busy is high while an item is in work; start is taken only when busy is low.
module ms2_peak_match_scorer #(
   parameter int MAX_LIB_PEAKS   = mpms_pkg::DEFAULT_MAX_LIB_PEAKS,
   parameter int SCORE_FRAC_BITS = mpms_pkg::DEFAULT_SCORE_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [mpms_pkg::MZ_W-1:0]       req_peak_mz,
   input  logic [mpms_pkg::INTEN_W-1:0]    req_peak_intensity,
   output logic                            rsp_valid,
   output logic [mpms_pkg::FRACTION_W-1:0] rsp_matched_fraction,
   output logic [mpms_pkg::FRACTION_W-1:0] rsp_intensity_fraction,
   output logic [mpms_pkg::ENTRIES_W-1:0]  rsp_matched_entries,
   output logic                            rsp_both_nonzero,
   output logic                            rsp_library_overflow,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpms_pkg::PPM_W-1:0]      csr_wdata
);
   import mpms_pkg::*;

   localparam int AW    = $clog2(MAX_LIB_PEAKS);
   localparam int CW    = $clog2(MAX_LIB_PEAKS + 1);
   localparam int QW    = SCORE_FRAC_BITS + 1;
   localparam int SUM_W = (INTEN_W + CW > TOTAL_W) ? INTEN_W + CW : TOTAL_W;
   localparam int WIN_W = 3 * MZ_W;
   localparam int BST_W = MZ_W + INTEN_W;

   mpms_state_type state_ff, state_in;
   mpms_action_type act;

   logic [PPM_W-1:0]      ppm_ff;
   logic [CW-1:0]         lib_count_ff;
   logic                  overflow_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [CW-1:0]         matched_count_ff;
   logic [SUM_W-1:0]      matched_sum_ff;
   logic [MAX_LIB_PEAKS-1:0] marks_ff;

   logic [MZ_W-1:0]       mz_ff;
   logic [INTEN_W-1:0]    inten_ff;
   logic [MZ_W+PPM_W-1:0] p_ff;
   logic [DELTA_W-1:0]    q0_ff;
   logic [MZ_W+PPM_W:0]   qm_ff;
   logic [CW-1:0]         lo_ff, hp1_ff;
   logic [AW-1:0]         mid_ff;
   logic [QW-1:0]         s1_ff, s2_ff;

   logic [WIN_W-1:0]      win_mem [MAX_LIB_PEAKS];
   logic [BST_W-1:0]      best_mem [MAX_LIB_PEAKS];
   logic [WIN_W-1:0]      win_rd_ff;
   logic [BST_W-1:0]      best_rd_ff;

   logic                  accept;
   logic                  div_start, div_done;
   logic [TOTAL_W-1:0]    div_numer, div_denom;
   logic [QW-1:0]         div_quot;

   logic [CW:0]           mid_sum;
   logic [AW-1:0]         mid;
   logic [MZ_W-1:0]       win_low, win_high, win_center, peak_dist;
   logic [MZ_W-1:0]       best_dist;
   logic [INTEN_W-1:0]    best_inten;
   logic                  hit, mark, first_hit, better_hit;
   logic [CW-1:0]         lo_nx, hp1_nx;
   logic [TOTAL_W:0]      total_sum;
   logic [SUM_W-1:0]      total_ext;
   logic [TOTAL_W-1:0]    msum_clip;

   logic [2*MZ_W+PPM_W+1:0] recip_prod;
   logic [MZ_W+PPM_W:0]   rem_val;
   logic [DELTA_W-1:0]    delta;
   logic [MZ_W:0]         high_sum;
   logic [MZ_W-1:0]       win_hi_sat;

   logic [QW+FRACTION_W-1:0] s1_ext, s2_ext;
   logic [CW+ENTRIES_W-1:0]  cnt_ext;

   assign act    = mpms_action_type'(req_action);
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Load datapath.
   assign recip_prod = (2*MZ_W+PPM_W+2)'(p_ff * PPM_RECIP);
   assign rem_val    = {1'b0, p_ff} - qm_ff;
   assign delta      = q0_ff + DELTA_W'(rem_val >= (MZ_W+PPM_W+1)'(PPM_SCALE));
   assign high_sum   = {1'b0, mz_ff} + (MZ_W+1)'(delta);
   assign win_hi_sat = (high_sum > {1'b0, MZ_MAX}) ? MZ_MAX : high_sum[MZ_W-1:0];

   // Search datapath.
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hp1_ff} - (CW+1)'(1);
   assign mid        = mid_sum[AW:1];
   assign win_low    = win_rd_ff[3*MZ_W-1:2*MZ_W];
   assign win_high   = win_rd_ff[2*MZ_W-1:MZ_W];
   assign win_center = win_rd_ff[MZ_W-1:0];
   assign best_dist  = best_rd_ff[BST_W-1:INTEN_W];
   assign best_inten = best_rd_ff[INTEN_W-1:0];
   assign peak_dist  = (win_center >= mz_ff) ? (win_center - mz_ff) : (mz_ff - win_center);
   assign hit        = (mz_ff >= win_low) && (mz_ff <= win_high);
   assign mark       = marks_ff[mid_ff];
   assign first_hit  = (state_ff == ST_COMPARE) && hit && !mark;
   assign better_hit = (state_ff == ST_COMPARE) && hit && mark && (peak_dist <= best_dist);
   assign lo_nx      = (!hit && !(mz_ff <= win_low)) ? (CW'(mid_ff) + CW'(1)) : lo_ff;
   assign hp1_nx     = (!hit && (mz_ff <= win_low)) ? CW'(mid_ff) : hp1_ff;

   assign total_sum  = {1'b0, total_ff} + (TOTAL_W+1)'(req_peak_intensity);
   assign total_ext  = SUM_W'(total_ff);
   assign msum_clip  = (matched_sum_ff > total_ext) ? total_ff : matched_sum_ff[TOTAL_W-1:0];

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_numer = TOTAL_W'(matched_count_ff);
      div_denom = TOTAL_W'(lib_count_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  ACT_LOAD: begin
                     if (lib_count_ff != CW'(MAX_LIB_PEAKS)) begin
                        state_in = ST_LD_MUL;
                     end
                  end
                  ACT_SAMPLE: begin
                     if (lib_count_ff != '0) begin
                        state_in = ST_PROBE;
                     end
                  end
                  ACT_FINISH: state_in = ST_DIV_CNT;
                  ACT_CLEAR:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_MUL:   state_in = ST_LD_RECIP;
         ST_LD_RECIP: state_in = ST_LD_BACK;
         ST_LD_BACK:  state_in = ST_LD_WRITE;
         ST_LD_WRITE: state_in = ST_IDLE;
         ST_PROBE:    state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (hit || !(lo_nx < hp1_nx)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_DIV_CNT: begin
            if (lib_count_ff == '0) begin
               state_in = ST_DIV_INT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT_CNT;
            end
         end
         ST_WAIT_CNT: begin
            if (div_done) begin
               state_in = ST_DIV_INT;
            end
         end
         ST_DIV_INT: begin
            div_numer = msum_clip;
            div_denom = total_ff;
            if (total_ff == '0) begin
               state_in = ST_REPORT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT_INT;
            end
         end
         ST_WAIT_INT: begin
            if (div_done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff           <= PPM_RESET;
         lib_count_ff     <= '0;
         overflow_ff      <= 1'b0;
         total_ff         <= '0;
         matched_count_ff <= '0;
         matched_sum_ff   <= '0;
         marks_ff         <= '0;
         rsp_valid        <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_valid && csr_ready) begin
            ppm_ff <= csr_wdata;
         end
         if (accept) begin
            priority if (act == ACT_LOAD) begin
               if (lib_count_ff == CW'(MAX_LIB_PEAKS)) begin
                  overflow_ff <= 1'b1;
               end
            end else if (act == ACT_SAMPLE) begin
               total_ff <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            end else if (act == ACT_CLEAR) begin
               lib_count_ff     <= '0;
               overflow_ff      <= 1'b0;
               total_ff         <= '0;
               matched_count_ff <= '0;
               matched_sum_ff   <= '0;
               marks_ff         <= '0;
            end
         end
         if (state_ff == ST_LD_WRITE) begin
            lib_count_ff <= lib_count_ff + CW'(1);
         end
         if (first_hit) begin
            marks_ff[mid_ff] <= 1'b1;
            matched_count_ff <= matched_count_ff + CW'(1);
            matched_sum_ff   <= matched_sum_ff + SUM_W'(inten_ff);
         end else if (better_hit) begin
            matched_sum_ff <= matched_sum_ff - SUM_W'(best_inten) + SUM_W'(inten_ff);
         end
         if (state_ff == ST_REPORT) begin
            rsp_valid        <= 1'b1;
            total_ff         <= '0;
            matched_count_ff <= '0;
            matched_sum_ff   <= '0;
            marks_ff         <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mz_ff    <= req_peak_mz;
         inten_ff <= req_peak_intensity;
         lo_ff    <= '0;
         hp1_ff   <= lib_count_ff;
      end
      unique case (state_ff)
         ST_LD_MUL:   p_ff  <= (MZ_W+PPM_W)'(mz_ff * ppm_ff);
         ST_LD_RECIP: q0_ff <= recip_prod[RECIP_SHIFT+DELTA_W-1:RECIP_SHIFT];
         ST_LD_BACK:  qm_ff <= (MZ_W+PPM_W+1)'(q0_ff * PPM_SCALE);
         ST_PROBE:    mid_ff <= mid;
         ST_COMPARE: begin
            lo_ff  <= lo_nx;
            hp1_ff <= hp1_nx;
         end
         ST_DIV_CNT: begin
            s1_ff <= '0;
         end
         ST_WAIT_CNT: begin
            if (div_done) begin
               s1_ff <= div_quot;
            end
         end
         ST_DIV_INT: begin
            s2_ff <= '0;
         end
         ST_WAIT_INT: begin
            if (div_done) begin
               s2_ff <= div_quot;
            end
         end
         ST_REPORT: begin
            rsp_matched_fraction   <= s1_ext[FRACTION_W-1:0];
            rsp_intensity_fraction <= s2_ext[FRACTION_W-1:0];
            rsp_matched_entries    <= cnt_ext[ENTRIES_W-1:0];
            rsp_both_nonzero       <= (s1_ff != '0) && (s2_ff != '0);
            rsp_library_overflow   <= overflow_ff;
         end
         default: begin
         end
      endcase
   end

   assign s1_ext  = (QW+FRACTION_W)'(s1_ff);
   assign s2_ext  = (QW+FRACTION_W)'(s2_ff);
   assign cnt_ext = (CW+ENTRIES_W)'(matched_count_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_LD_WRITE) begin
         win_mem[lib_count_ff[AW-1:0]] <= {mz_ff - MZ_W'(delta), win_hi_sat, mz_ff};
      end
      if (state_ff == ST_PROBE) begin
         win_rd_ff <= win_mem[mid];
      end
   end

   always_ff @(posedge clock) begin
      if (first_hit || better_hit) begin
         best_mem[mid_ff] <= {peak_dist, inten_ff};
      end
      if (state_ff == ST_PROBE) begin
         best_rd_ff <= best_mem[mid];
      end
   end

   mpms_div #(
      .FRAC_BITS(SCORE_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      matched_count_ff <= lib_count_ff)
      else $error("matched count exceeds library size");

   a_lib_bound: assert property (@(posedge clock) disable iff (reset)
      lib_count_ff <= CW'(MAX_LIB_PEAKS))
      else $error("library count beyond capacity");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (matched_count_ff == '0) && (total_ff == '0) && (marks_ff == '0))
      else $error("sample side not cleared after result");

   a_compare_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> ($past(state_ff) == ST_PROBE))
      else $error("compare without a preceding memory read");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spectral peak match scorer. A queue of items is
// filled with library loads, sample peaks, finishes and clears; a driver feeds
// them under start/busy with random gaps, a scoring model predicts each finish
// result, and a monitor compares every rsp_valid item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import mpms_pkg::*;

   localparam int LIB_DEPTH = DEFAULT_MAX_LIB_PEAKS;
   localparam int FRAC_BITS = DEFAULT_SCORE_FRAC_BITS;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 1700;

   typedef struct packed {
      mpms_action_type     action;
      logic [MZ_W-1:0]     mz;
      logic [INTEN_W-1:0]  inten;
   } peak_item_type;

   typedef struct packed {
      logic [FRACTION_W-1:0] mfrac;
      logic [FRACTION_W-1:0] ifrac;
      logic [ENTRIES_W-1:0]  entries;
      logic                  both;
      logic                  ovf;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [MZ_W-1:0] req_peak_mz = '0;
   logic [INTEN_W-1:0] req_peak_intensity = '0;
   logic rsp_valid;
   logic [FRACTION_W-1:0] rsp_matched_fraction, rsp_intensity_fraction;
   logic [ENTRIES_W-1:0] rsp_matched_entries;
   logic rsp_both_nonzero, rsp_library_overflow;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [PPM_W-1:0] csr_wdata = '0;

   ms2_peak_match_scorer dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Scoring model state.
   logic [PPM_W-1:0]   ppm;
   logic [MZ_W-1:0]    win_lo [LIB_DEPTH];
   logic [MZ_W-1:0]    win_hi [LIB_DEPTH];
   logic [MZ_W-1:0]    center [LIB_DEPTH];
   logic [MZ_W-1:0]    best_dist [LIB_DEPTH];
   logic [INTEN_W-1:0] best_inten [LIB_DEPTH];
   logic               hit [LIB_DEPTH];
   int unsigned        lib_cnt, hit_cnt;
   logic [TOTAL_W-1:0] total_inten, hit_inten;
   logic               lib_ovf;

   peak_item_type pending_items[$];
   score_type     expected_scores[$];
   int         errors = 0;
   int         queued = 0;
   int         drv_gap = 0;
   logic       hold_off = 1'b0;
   logic       stim_done = 1'b0;
   int         idle_cycles = 0;

   task automatic clear_sample_side();
      for (int i = 0; i < LIB_DEPTH; i++) hit[i] = 1'b0;
      hit_cnt = 0;
      hit_inten = '0;
      total_inten = '0;
   endtask

   task automatic score_item(peak_item_type it);
      logic [63:0] delta, upper, msum, s1, s2;
      logic [MZ_W-1:0] peak_dist;
      int lo, hi, mid;
      score_type sc;
      case (it.action)
         ACT_LOAD: begin
            if (lib_cnt >= LIB_DEPTH) begin
               lib_ovf = 1'b1;
            end else begin
               delta = (64'(it.mz) * ppm) / 64'd1000000;
               upper = 64'(it.mz) + delta;
               if (upper > 64'(MZ_MAX)) upper = 64'(MZ_MAX);
               win_lo[lib_cnt] = MZ_W'(64'(it.mz) - delta);
               win_hi[lib_cnt] = MZ_W'(upper);
               center[lib_cnt] = it.mz;
               hit[lib_cnt] = 1'b0;
               lib_cnt++;
            end
         end
         ACT_SAMPLE: begin
            upper = 64'(total_inten) + it.inten;
            total_inten = (upper > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(upper);
            lo = 0;
            hi = int'(lib_cnt) - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (it.mz >= win_lo[mid] && it.mz <= win_hi[mid]) begin
                  peak_dist = (center[mid] >= it.mz) ? center[mid] - it.mz
                                                     : it.mz - center[mid];
                  if (!hit[mid]) begin
                     hit[mid] = 1'b1;
                     hit_cnt++;
                     best_dist[mid] = peak_dist;
                     best_inten[mid] = it.inten;
                     hit_inten = hit_inten + it.inten;
                  end else if (peak_dist <= best_dist[mid]) begin
                     hit_inten = hit_inten - best_inten[mid] + it.inten;
                     best_dist[mid] = peak_dist;
                     best_inten[mid] = it.inten;
                  end
                  break;
               end else if (it.mz <= win_lo[mid]) begin
                  hi = mid - 1;
               end else begin
                  lo = mid + 1;
               end
            end
         end
         ACT_CLEAR: begin
            lib_cnt = 0;
            lib_ovf = 1'b0;
            clear_sample_side();
         end
         default: begin
            s1 = 0;
            s2 = 0;
            if (lib_cnt != 0) s1 = (64'(hit_cnt) << FRAC_BITS) / lib_cnt;
            if (total_inten != 0) begin
               msum = hit_inten;
               if (msum > 64'(total_inten)) msum = total_inten;
               s2 = (msum << FRAC_BITS) / total_inten;
            end
            sc.mfrac = FRACTION_W'(s1);
            sc.ifrac = FRACTION_W'(s2);
            sc.entries = ENTRIES_W'(hit_cnt);
            sc.both = (s1 != 0) && (s2 != 0);
            sc.ovf = lib_ovf;
            expected_scores.insert(expected_scores.size(), sc);
            clear_sample_side();
         end
      endcase
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver.
   always @(posedge clock) begin
      peak_item_type it;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // Holding the current item until it is taken.
      end else begin
         if (start) score_item({mpms_action_type'(req_action), req_peak_mz,
                                req_peak_intensity});
         if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            start <= 1'b0;
         end else if (!hold_off && pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_action <= it.action;
            req_peak_mz <= it.mz;
            req_peak_intensity <= it.inten;
            start <= 1'b1;
            drv_gap <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      score_type sc;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_scores.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               sc = expected_scores.pop_front();
               if (rsp_matched_fraction !== sc.mfrac)
                  report("matched_fraction", rsp_matched_fraction, sc.mfrac);
               if (rsp_intensity_fraction !== sc.ifrac)
                  report("intensity_fraction", rsp_intensity_fraction, sc.ifrac);
               if (rsp_matched_entries !== sc.entries)
                  report("matched_entries", rsp_matched_entries, sc.entries);
               if (rsp_both_nonzero !== sc.both)
                  report("both_nonzero", rsp_both_nonzero, sc.both);
               if (rsp_library_overflow !== sc.ovf)
                  report("library_overflow", rsp_library_overflow, sc.ovf);
            end
         end
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic peak_item_type mk(mpms_action_type a, logic [MZ_W-1:0] m,
                                        logic [INTEN_W-1:0] i);
      peak_item_type it;
      it.action = a;
      it.mz = m;
      it.inten = i;
      return it;
   endfunction

   task automatic add_item(peak_item_type it);
      pending_items.insert(pending_items.size(), it);
      queued++;
   endtask

   function automatic logic [INTEN_W-1:0] rand_inten();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 255);
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Builds one spectrum: ascending library, samples mostly near it, a finish.
   task automatic queue_spectrum(int nlib, int nsamp, bit big);
      logic [MZ_W-1:0] lib_mz [$];
      logic [MZ_W-1:0] m, w;
      int step, k;
      m = big ? MZ_W'($urandom_range(0, 5000)) : MZ_W'($urandom_range(1000, 400000));
      step = big ? 250000 : $urandom_range(2, 40000);
      for (int i = 0; i < nlib; i++) begin
         lib_mz.insert(lib_mz.size(), m);
         add_item(mk(ACT_LOAD, m, $urandom));
         if (64'(m) + step + 1 > 64'(MZ_MAX)) break;
         m = m + MZ_W'($urandom_range(1, step));
      end
      for (int i = 0; i < nsamp; i++) begin
         if ($urandom_range(0, 9) < 8 && lib_mz.size() > 0) begin
            k = $urandom_range(0, lib_mz.size() - 1);
            w = MZ_W'((64'(lib_mz[k]) * 1000) / 1000000 + 1);
            m = lib_mz[k] + MZ_W'($urandom_range(0, 2 * w)) - w;
         end else begin
            m = MZ_W'($urandom);
         end
         add_item(mk(ACT_SAMPLE, m, rand_inten()));
      end
      add_item(mk(ACT_FINISH, '0, '0));
   endtask

   task automatic drain(int settle);
      while (pending_items.size() > 0) @(posedge clock);
      hold_off = 1'b1;
      @(posedge clock);
      while (start || busy || expected_scores.size() > 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
      hold_off = 1'b0;
   endtask

   task automatic write_ppm(logic [PPM_W-1:0] v);
      drain(60);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ppm = v;
   endtask

   initial begin
      ppm = PPM_RESET;
      lib_cnt = 0;
      lib_ovf = 1'b0;
      clear_sample_side();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty finish, extremes, clear, ties, tolerance edges.
      add_item(mk(ACT_FINISH, '0, '0));
      add_item(mk(ACT_SAMPLE, '0, '1));
      add_item(mk(ACT_FINISH, '0, '0));
      add_item(mk(ACT_LOAD, '0, '1));
      add_item(mk(ACT_LOAD, 26'd1000000, '0));
      add_item(mk(ACT_LOAD, MZ_MAX, '0));
      add_item(mk(ACT_SAMPLE, 26'd1000010, 32'd5));
      add_item(mk(ACT_SAMPLE, 26'd999990, 32'd7));
      add_item(mk(ACT_SAMPLE, 26'd1000011, 32'd9));
      add_item(mk(ACT_SAMPLE, MZ_MAX, '1));
      add_item(mk(ACT_SAMPLE, '0, '1));
      add_item(mk(ACT_SAMPLE, 26'd1, '0));
      add_item(mk(ACT_FINISH, '0, '0));
      add_item(mk(ACT_SAMPLE, 26'd5000, 32'd3));
      add_item(mk(ACT_FINISH, '0, '0));
      add_item(mk(ACT_CLEAR, MZ_MAX, '1));
      add_item(mk(ACT_FINISH, '0, '0));
      drain(0);

      write_ppm('0);
      queue_spectrum(4, 6, 0);
      write_ppm(10'd1000);
      queue_spectrum(6, 8, 0);
      queue_spectrum(3, 4, 1);
      // Fill the library past capacity.
      write_ppm(10'd1023);
      add_item(mk(ACT_CLEAR, '0, '0));
      queue_spectrum(LIB_DEPTH + 3, 30, 1);
      add_item(mk(ACT_SAMPLE, 26'd12345, '1));
      add_item(mk(ACT_FINISH, '0, '0));
      add_item(mk(ACT_CLEAR, '0, '0));
      add_item(mk(ACT_FINISH, '0, '0));

      while (queued < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) write_ppm(PPM_W'($urandom_range(0, 1023)));
         add_item(mk(ACT_CLEAR, '0, '0));
         case ($urandom_range(0, 5))
            0: queue_spectrum($urandom_range(0, 2), $urandom_range(0, 4), 0);
            1: begin
               add_item(mk(mpms_action_type'($urandom_range(0, 3)),
                           MZ_W'($urandom), $urandom));
               add_item(mk(ACT_FINISH, '0, '0));
            end
            default: queue_spectrum($urandom_range(1, 20), $urandom_range(1, 25), 0);
         endcase
         if ($urandom_range(0, 3) == 0) add_item(mk(ACT_FINISH, '0, '0));
         while (pending_items.size() > 40) @(posedge clock);
      end
      drain(60);
      stim_done = 1'b1;
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/mpms_pkg.sv
hw/rtl/mpms_div.sv
hw/rtl/ms2_peak_match_scorer.sv
dv/tb.sv
